// ===== hw/rtl/dsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// DFA string matcher package
// Shared widths, command codes, table sizes and helper types.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int STATE_COUNT = 64;
  localparam int SYMBOL_W    = 8;
  localparam int STATE_W     = 6;
  localparam int TOKEN_W     = 8;
  localparam int SIDX_W      = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
  localparam int TADDR_W     = SIDX_W + SYMBOL_W;
  localparam int TRANS_DEPTH = STATE_COUNT * (1 << SYMBOL_W);
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_AW       = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W    = OQ_AW + 1;

  typedef logic [STATE_W-1:0]  state_t;
  typedef logic [SYMBOL_W-1:0] symbol_t;
  typedef logic [TOKEN_W-1:0]  token_t;
  typedef logic [SIDX_W-1:0]   sidx_t;
  typedef logic [TADDR_W-1:0]  taddr_t;

  typedef enum logic [1:0] {
    CMD_LOAD_TRANS = 2'd0,
    CMD_LOAD_TOKEN = 2'd1,
    CMD_MATCH      = 2'd2
  } cmd_t;

  typedef struct packed {
    logic   present;
    state_t next_state;
  } trans_entry_t;

  typedef struct packed {
    logic   accepted;
    token_t token_id;
  } out_item_t;

  function automatic sidx_t state_idx(input state_t s);
    return sidx_t'(s);
  endfunction

  function automatic logic state_in_range(input state_t s);
    return (32'(s) < STATE_COUNT);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dsm_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// DFA string matcher input channel
// Valid/ready channel carrying load and match commands.
// ----------------------------------------------------------------------------
interface dsm_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  dsm_pkg::state_t     table_state;
  dsm_pkg::symbol_t    symbol;
  dsm_pkg::state_t     next_state;
  logic                present;
  dsm_pkg::token_t     token_value;
  logic                last_byte;

  modport source (
    output valid, cmd, table_state, symbol, next_state, present, token_value, last_byte,
    input  ready
  );

  modport sink (
    input  valid, cmd, table_state, symbol, next_state, present, token_value, last_byte,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/dsm_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// DFA string matcher result channel
// Valid/ready channel carrying the verdict for each finished string.
// ----------------------------------------------------------------------------
interface dsm_out_if;
  logic            valid;
  logic            ready;
  logic            accepted;
  dsm_pkg::token_t token_id;

  modport source (
    output valid, accepted, token_id,
    input  ready
  );

  modport sink (
    input  valid, accepted, token_id,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/dfa_string_matcher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// DFA string matcher unit
// Table-driven DFA matcher: load transactions fill the transition and token
// tables, match transactions walk one byte per cycle through the DFA while ready is high.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// in_chan   sink       cmd, table_state, symbol, next_state, present,
//                      token_value, last_byte
// out_chan  source     accepted, token_id (one per last byte)
// cfg_*     write      start_state
//
// One transaction is accepted per cycle while in_chan.ready is high. The
// transition table read is the loop: its registered read data feeds the
// address for the next byte. A verdict passes m1 and m2 registers, then a
// four-entry output queue; input is held off only when that queue could fill
// or during the clearing pass after reset, which empties the tables by
// walking STATE_COUNT * 256 (16384) entries, accepting no input transaction.
// ----------------------------------------------------------------------------
module dfa_string_matcher_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  dsm_in_if.sink               in_chan,
  dsm_out_if.source            out_chan,
  input  wire logic            cfg_we,
  input  wire dsm_pkg::state_t cfg_wdata
);
  import dsm_pkg::*;

  trans_entry_t trans_mem_r [0:TRANS_DEPTH-1];
  token_t       tok_mem_r   [0:STATE_COUNT-1];
  out_item_t    fifo_r      [0:OQ_DEPTH-1];

  logic         clr_busy_r;
  taddr_t       clr_addr_r;

  state_t       start_r;
  state_t       cs_r;
  logic         fail_r;

  logic         m1_valid_r;
  logic         m1_last_r;
  logic         m1_fail_r;
  logic         m1_inrange_r;
  state_t       m1_state_r;
  trans_entry_t trans_rd_r;

  logic         m2_valid_r;
  logic         m2_acc_r;
  logic         m2_inrange_r;
  token_t       tok_rd_r;

  logic [OQ_AW-1:0]    wr_ptr_r;
  logic [OQ_AW-1:0]    rd_ptr_r;
  logic [OQ_CNT_W-1:0] count_r;

  state_t       s1_state;
  logic         s1_fail;
  state_t       cur_state;
  logic         cur_fail;
  state_t       cs_nxt;
  logic         fail_nxt;
  logic         in_fire;
  logic         is_match;
  logic         trans_we;
  logic         tok_we;
  logic         load_in_range;
  taddr_t       trans_raddr;
  taddr_t       trans_waddr;
  logic [OQ_CNT_W-1:0] pending;
  logic         push;
  logic         pop;
  out_item_t    push_item;

  // Stage 1: resolve the byte read in the previous cycle.
  always_comb begin
    if (m1_fail_r) begin
      s1_state = m1_state_r;
      s1_fail  = 1'b1;
    end else if (trans_rd_r.present && m1_inrange_r) begin
      s1_state = trans_rd_r.next_state;
      s1_fail  = 1'b0;
    end else begin
      s1_state = m1_state_r;
      s1_fail  = 1'b1;
    end
  end

  always_comb begin
    if (m1_valid_r && m1_last_r) begin
      cur_state = start_r;
      cur_fail  = 1'b0;
    end else if (m1_valid_r) begin
      cur_state = s1_state;
      cur_fail  = s1_fail;
    end else begin
      cur_state = cs_r;
      cur_fail  = fail_r;
    end
    if (cfg_we) begin
      cs_nxt   = cfg_wdata;
      fail_nxt = 1'b0;
    end else begin
      cs_nxt   = cur_state;
      fail_nxt = cur_fail;
    end
  end

  assign pending = count_r + OQ_CNT_W'(m1_valid_r & m1_last_r) + OQ_CNT_W'(m2_valid_r);
  assign in_chan.ready = !clr_busy_r && (pending < OQ_CNT_W'(OQ_DEPTH));
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign is_match      = in_fire && (in_chan.cmd == CMD_MATCH);
  assign load_in_range = state_in_range(in_chan.table_state);
  assign trans_we      = in_fire && (in_chan.cmd == CMD_LOAD_TRANS) && load_in_range;
  assign tok_we        = in_fire && (in_chan.cmd == CMD_LOAD_TOKEN) && load_in_range;
  assign trans_raddr   = {state_idx(cur_state), in_chan.symbol};
  assign trans_waddr   = {state_idx(in_chan.table_state), in_chan.symbol};

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      trans_mem_r[clr_addr_r] <= '0;
    end else if (trans_we) begin
      trans_mem_r[trans_waddr] <= in_chan.present ?
                                  {1'b1, in_chan.next_state} : '0;
    end
    trans_rd_r <= trans_mem_r[trans_raddr];
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      tok_mem_r[clr_addr_r[TADDR_W-1:SYMBOL_W]] <= '0;
    end else if (tok_we) begin
      tok_mem_r[state_idx(in_chan.table_state)] <= in_chan.token_value;
    end
    tok_rd_r <= tok_mem_r[state_idx(s1_state)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (32'(clr_addr_r) == TRANS_DEPTH - 1) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= '0;
      cs_r       <= '0;
      fail_r     <= 1'b0;
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      cs_r       <= cs_nxt;
      fail_r     <= fail_nxt;
      m1_valid_r <= is_match;
      m2_valid_r <= m1_valid_r && m1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_last_r    <= in_chan.last_byte;
    m1_fail_r    <= cur_fail;
    m1_state_r   <= cur_state;
    m1_inrange_r <= state_in_range(cur_state);
    m2_acc_r     <= !s1_fail;
    m2_inrange_r <= state_in_range(s1_state);
  end

  assign push               = m2_valid_r;
  assign pop                = out_chan.valid && out_chan.ready;
  assign push_item.accepted = m2_acc_r;
  assign push_item.token_id = (m2_acc_r && m2_inrange_r) ? tok_rd_r : '0;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  assign out_chan.valid    = (count_r != '0);
  assign out_chan.accepted = fifo_r[rd_ptr_r].accepted;
  assign out_chan.token_id = fifo_r[rd_ptr_r].token_id;

endmodule
`default_nettype wire
